// ----- design/rational_arithmetic_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared concurrent check forms, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau check failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau check failed");

`endif

// ----- design/rau_pkg.sv -----
// ---------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, mode codes, beat types and sign helpers shared by the unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int RES_W         = 32;
    localparam int MODE_W        = 3;

    localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RED = 3'd4;

    typedef logic signed [OPERAND_WIDTH-1:0] opnd_t;
    typedef logic        [OPERAND_WIDTH-1:0] mag_t;
    typedef logic signed [RES_W-1:0]         wide_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        opnd_t             a_num;
        opnd_t             a_den;
        opnd_t             b_num;
        opnd_t             b_den;
    } rau_in_t;

    typedef struct packed {
        wide_t res_num;
        wide_t res_den;
        logic  zero_gcd;
    } rau_out_t;

    typedef struct packed {
        logic go;
        mag_t num;
        mag_t den;
    } div_cmd_t;

    typedef struct packed {
        logic done;
        mag_t quo;
        mag_t rem;
    } div_rsp_t;

    function automatic mag_t mag(input opnd_t v);
        mag_t u;
        u = mag_t'(v);
        return v[OPERAND_WIDTH-1] ? mag_t'(~u + 1'b1) : u;
    endfunction

    function automatic wide_t sext(input opnd_t v);
        return wide_t'(v);
    endfunction

    function automatic wide_t apply_sign(input mag_t m, input logic neg);
        logic [RES_W-1:0] ext;
        ext = RES_W'(m);
        return neg ? wide_t'(~ext + 1'b1) : wide_t'(ext);
    endfunction

endpackage

// ----- design/rau_div.sv -----
// ---------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring unsigned divider, one quotient bit per cycle, shared by gcd
// remainder steps and the final reduce quotients.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_cmd_t cmd,
    output rau_pkg::div_rsp_t rsp
);

    localparam int W     = rau_pkg::OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    rau_pkg::mag_t     q_reg, q_next;
    rau_pkg::mag_t     r_reg, r_next;
    rau_pkg::mag_t     d_reg, d_next;
    logic [W+1:0]      diff;

    assign diff = {1'b0, r_reg, q_reg[W-1]} - {2'b00, d_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (cmd.go)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(W - 1);
            q_next   = cmd.num;
            r_next   = '0;
            d_next   = cmd.den;
        end
        else if (run_reg)
        begin
            if (!diff[W+1])
            begin
                r_next = diff[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;
    assign rsp.rem  = r_reg;

endmodule

// ----- design/rational_arithmetic_unit.sv -----
// ---------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply and divide of two fractions, or gcd reduction of
// the first, using one multiplier and one iterative divider.
// ---------------------------------------------------------------------------
// channel   ports                    handshake
// in        item                     start, taken when busy is low
// out       result                   done, one-cycle strobe
//
// Add, subtract, multiply, divide: states S_M0, S_M1, S_M2 on the shared multiplier, result in S_M3.
// Unused modes: result the cycle after the beat.
// Reduce: gcd remainder steps on the bit-serial divider (S_RCHK, S_RWT), then
// the numerator and denominator quotients by the gcd (S_G, S_Q1, S_Q2).
// No clearing pass after reset; the receiver cannot stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rau_pkg::rau_in_t  item,
    output logic              done,
    output rau_pkg::rau_out_t result
);

    localparam int W  = rau_pkg::OPERAND_WIDTH;
    localparam int SW = 4;

    localparam logic [SW-1:0] S_IDLE = 4'd0;
    localparam logic [SW-1:0] S_M0   = 4'd1;
    localparam logic [SW-1:0] S_M1   = 4'd2;
    localparam logic [SW-1:0] S_M2   = 4'd3;
    localparam logic [SW-1:0] S_M3   = 4'd4;
    localparam logic [SW-1:0] S_RCHK = 4'd5;
    localparam logic [SW-1:0] S_RWT  = 4'd6;
    localparam logic [SW-1:0] S_G    = 4'd7;
    localparam logic [SW-1:0] S_Q1   = 4'd8;
    localparam logic [SW-1:0] S_Q2   = 4'd9;

    logic [SW-1:0]       state_reg, state_next;
    logic                done_reg, done_next;
    rau_pkg::rau_in_t    item_reg, item_next;
    rau_pkg::rau_out_t   res_reg, res_next;
    logic                sx_reg, sx_next, sy_reg, sy_next;
    rau_pkg::mag_t       mx_reg, mx_next, my_reg, my_next;
    rau_pkg::wide_t      prod_reg, prod_next;
    rau_pkg::wide_t      num_reg, num_next;
    rau_pkg::opnd_t      mul_a, mul_b;
    rau_pkg::wide_t      mul_p;
    rau_pkg::div_cmd_t   div_cmd;
    rau_pkg::div_rsp_t   div_rsp;
    logic                accept;

    rau_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        mul_a = item_reg.a_num;
        mul_b = item_reg.b_den;
        unique case (state_reg)
            S_M0:
            begin
                mul_a = item_reg.a_num;
                mul_b = (item_reg.mode == rau_pkg::MODE_MUL) ? item_reg.b_num : item_reg.b_den;
            end
            S_M1:
            begin
                mul_a = item_reg.b_num;
                mul_b = item_reg.a_den;
            end
            S_M2:
            begin
                mul_a = item_reg.a_den;
                mul_b = (item_reg.mode == rau_pkg::MODE_DIV) ? item_reg.b_num : item_reg.b_den;
            end
            default:
            begin
                mul_a = item_reg.a_num;
                mul_b = item_reg.b_den;
            end
        endcase
    end

    assign mul_p = rau_pkg::sext(mul_a) * rau_pkg::sext(mul_b);

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        item_next   = item_reg;
        res_next    = res_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        prod_next   = prod_reg;
        num_next    = num_reg;
        div_cmd     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = item;
                    sx_next   = item.a_den[W-1];
                    mx_next   = rau_pkg::mag(item.a_den);
                    sy_next   = item.a_num[W-1];
                    my_next   = rau_pkg::mag(item.a_num);
                    case (item.mode) inside
                        rau_pkg::MODE_ADD, rau_pkg::MODE_SUB,
                        rau_pkg::MODE_MUL, rau_pkg::MODE_DIV:
                            state_next = S_M0;
                        rau_pkg::MODE_RED:
                            state_next = S_RCHK;
                        default:
                        begin
                            res_next.res_num  = rau_pkg::sext(item.a_num);
                            res_next.res_den  = rau_pkg::sext(item.a_den);
                            res_next.zero_gcd = 1'b0;
                            done_next         = 1'b1;
                        end
                    endcase
                end
            end
            S_M0:
            begin
                prod_next  = mul_p;
                state_next = S_M1;
            end
            S_M1:
            begin
                num_next   = prod_reg;
                prod_next  = mul_p;
                state_next = S_M2;
            end
            S_M2:
            begin
                case (item_reg.mode)
                    rau_pkg::MODE_ADD: num_next = num_reg + prod_reg;
                    rau_pkg::MODE_SUB: num_next = num_reg - prod_reg;
                    default:           num_next = num_reg;
                endcase
                prod_next  = mul_p;
                state_next = S_M3;
            end
            S_M3:
            begin
                res_next.res_num  = num_reg;
                res_next.res_den  = prod_reg;
                res_next.zero_gcd = 1'b0;
                done_next         = 1'b1;
                state_next        = S_IDLE;
            end
            S_RCHK:
            begin
                if (my_reg == '0)
                    state_next = S_G;
                else
                begin
                    div_cmd.go  = 1'b1;
                    div_cmd.num = mx_reg;
                    div_cmd.den = my_reg;
                    state_next  = S_RWT;
                end
            end
            S_RWT:
            begin
                if (div_rsp.done)
                begin
                    sx_next = sy_reg;
                    mx_next = my_reg;
                    sy_next = sx_reg;
                    my_next = div_rsp.rem;
                    if (div_rsp.rem == '0)
                        state_next = S_G;
                    else
                    begin
                        div_cmd.go  = 1'b1;
                        div_cmd.num = my_reg;
                        div_cmd.den = div_rsp.rem;
                    end
                end
            end
            S_G:
            begin
                if (mx_reg == '0)
                begin
                    res_next.res_num  = rau_pkg::sext(item_reg.a_num);
                    res_next.res_den  = rau_pkg::sext(item_reg.a_den);
                    res_next.zero_gcd = 1'b1;
                    done_next         = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    div_cmd.go  = 1'b1;
                    div_cmd.num = rau_pkg::mag(item_reg.a_num);
                    div_cmd.den = mx_reg;
                    state_next  = S_Q1;
                end
            end
            S_Q1:
            begin
                if (div_rsp.done)
                begin
                    num_next    = rau_pkg::apply_sign(div_rsp.quo, item_reg.a_num[W-1] ^ sx_reg);
                    div_cmd.go  = 1'b1;
                    div_cmd.num = rau_pkg::mag(item_reg.a_den);
                    div_cmd.den = mx_reg;
                    state_next  = S_Q2;
                end
            end
            S_Q2:
            begin
                if (div_rsp.done)
                begin
                    res_next.res_num  = num_reg;
                    res_next.res_den  = rau_pkg::apply_sign(div_rsp.quo,
                                                            item_reg.a_den[W-1] ^ sx_reg);
                    res_next.zero_gcd = 1'b0;
                    done_next         = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
    end

    `RAU_ASSERT_NOW(a_done_idle, done, !busy)
    `RAU_ASSERT_NEXT(a_accept_moves, accept, busy || done)
    `RAU_ASSERT_NOW(a_zero_gcd_pass, done && result.zero_gcd, result.res_num == 0 && result.res_den == 0)
    `RAU_ASSERT_NOW(a_div_owner, div_rsp.done, state_reg == S_RWT || state_reg == S_Q1 || state_reg == S_Q2)

endmodule

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction beats through the start/busy command port, first from a
// directed vector table and then at random, with idle gaps of random length.
// A fraction predictor, or the table's own want, gives the expected result
// of each accepted beat; each done is matched field by field in issue order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import rau_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_BEATS = 700;
    localparam int DRAIN_EVERY  = 100;
    localparam int LINGER       = 500;
    localparam int STALL_LIMIT  = 5000;
    localparam int REPORT_MAX   = 10;
    localparam int NUM_VECTORS  = 24;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        rau_in_t  stim;
        logic     has_want;
        rau_out_t want;
    } vector_t;

    localparam rau_out_t NO_WANT = '0;

    localparam vector_t VECTORS [0:NUM_VECTORS-1] = '{
        '{'{MODE_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3}, 1'b1, '{32'sd5, 32'sd6, 1'b0}},
        '{'{MODE_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3}, 1'b1, '{32'sd1, 32'sd6, 1'b0}},
        '{'{MODE_MUL, 16'sd2, 16'sd3, 16'sd5, 16'sd7}, 1'b1, '{32'sd10, 32'sd21, 1'b0}},
        '{'{MODE_DIV, 16'sd2, 16'sd3, 16'sd5, 16'sd7}, 1'b1, '{32'sd14, 32'sd15, 1'b0}},
        '{'{MODE_RED, 16'sd6, 16'sd4, 16'sd0, 16'sd0}, 1'b1, '{32'sd3, 32'sd2, 1'b0}},
        '{'{MODE_RED, 16'sd0, 16'sd0, 16'h7FFF, 16'h8000}, 1'b1,
          '{32'sd0, 32'sd0, 1'b1}},
        '{'{MODE_RED, 16'sd0, 16'sd5, 16'sd0, 16'sd0}, 1'b1, '{32'sd0, 32'sd1, 1'b0}},
        '{'{MODE_RED, 16'sd7, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{32'sd1, 32'sd0, 1'b0}},
        '{'{MODE_RED, -16'sd6, 16'sd4, 16'sd0, 16'sd0}, 1'b1, '{32'sd3, -32'sd2, 1'b0}},
        '{'{MODE_MUL, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 1'b1,
          '{32'sd1073741824, 32'sd1073676289, 1'b0}},
        '{'{MODE_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1,
          '{32'sh80000000, 32'sh40000000, 1'b0}},
        '{'{MODE_SUB, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}, 1'b0, NO_WANT},
        '{'{MODE_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5}, 1'b1, '{32'sd15, 32'sd0, 1'b0}},
        '{'{MODE_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
        '{'{MODE_SPARE_LO, 16'sd9, -16'sd3, 16'sd1, 16'sd1}, 1'b1,
          '{32'sd9, -32'sd3, 1'b0}},
        '{'{MODE_SPARE_MID, 16'h8000, 16'h7FFF, 16'sd0, 16'sd0}, 1'b1,
          '{-32'sd32768, 32'sd32767, 1'b0}},
        '{'{MODE_SPARE_HI, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{32'sd32767, -32'sd32768, 1'b0}},
        '{'{MODE_RED, 16'sd10, 16'sd15, 16'h8000, 16'hFFFF}, 1'b1,
          '{32'sd2, 32'sd3, 1'b0}},
        '{'{MODE_RED, 16'sd28657, 16'sd17711, 16'sd0, 16'sd0}, 1'b0, NO_WANT},
        '{'{MODE_RED, 16'h8000, 16'h8000, 16'sd0, 16'sd0}, 1'b1, '{32'sd1, 32'sd1, 1'b0}},
        '{'{MODE_RED, 16'h8000, 16'sd1, 16'sd0, 16'sd0}, 1'b1,
          '{-32'sd32768, 32'sd1, 1'b0}},
        '{'{MODE_RED, 16'sd1, 16'h8000, 16'sd0, 16'sd0}, 1'b1,
          '{32'sd1, -32'sd32768, 1'b0}},
        '{'{MODE_DIV, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{32'sd1, 32'sd1, 1'b0}},
        '{'{MODE_MUL, 16'sd0, 16'h7FFF, 16'h8000, 16'hFFFF}, 1'b0, NO_WANT}
    };

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    rau_in_t  item;
    logic     done;
    rau_out_t result;

    rau_out_t awaited_fractions [$];
    int       mismatches;
    int       stall_cycles;
    bit       steady;

    rational_arithmetic_unit DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    function automatic rau_out_t fraction_result(input rau_in_t beat);
        longint   an;
        longint   ad;
        longint   bn;
        longint   bd;
        longint   x;
        longint   y;
        longint   r;
        rau_out_t res;
        an = $signed(beat.a_num);
        ad = $signed(beat.a_den);
        bn = $signed(beat.b_num);
        bd = $signed(beat.b_den);
        res.res_num  = wide_t'(an);
        res.res_den  = wide_t'(ad);
        res.zero_gcd = 1'b0;
        case (beat.mode)
            MODE_ADD:
            begin
                res.res_num = wide_t'(an * bd + bn * ad);
                res.res_den = wide_t'(ad * bd);
            end
            MODE_SUB:
            begin
                res.res_num = wide_t'(an * bd - bn * ad);
                res.res_den = wide_t'(ad * bd);
            end
            MODE_MUL:
            begin
                res.res_num = wide_t'(an * bn);
                res.res_den = wide_t'(ad * bd);
            end
            MODE_DIV:
            begin
                res.res_num = wide_t'(an * bd);
                res.res_den = wide_t'(ad * bn);
            end
            MODE_RED:
            begin
                x = ad;
                y = an;
                while (y != 0)
                begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                if (x == 0)
                    res.zero_gcd = 1'b1;
                else
                begin
                    res.res_num = wide_t'(an / x);
                    res.res_den = wide_t'(ad / x);
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic opnd_t pick_operand();
        case ($urandom_range(0, 9))
            0:       return opnd_t'(16'h8000);
            1:       return opnd_t'(16'h7FFF);
            2:       return opnd_t'($urandom_range(0, 2)) - opnd_t'(1);
            3, 4:    return opnd_t'($urandom_range(0, 40)) - opnd_t'(20);
            default: return opnd_t'($urandom);
        endcase
    endfunction

    function automatic opnd_t scaled_operand(input int scale);
        int factor;
        factor = $urandom_range(0, 362) - 181;
        return opnd_t'(scale * factor);
    endfunction

    function automatic rau_in_t random_beat();
        rau_in_t beat;
        int      pick;
        int      scale;
        beat.a_num = pick_operand();
        beat.a_den = pick_operand();
        beat.b_num = pick_operand();
        beat.b_den = pick_operand();
        pick = $urandom_range(0, 99);
        if (pick < 55)
            beat.mode = MODE_W'($urandom_range(MODE_ADD, MODE_DIV));
        else if (pick < 63)
            beat.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        else
        begin
            beat.mode = MODE_RED;
            if (pick < 67)
            begin
                beat.a_num = '0;
                beat.a_den = '0;
            end
            else if (pick < 92)
            begin
                scale = $urandom_range(1, 181);
                if ($urandom_range(0, 1) == 1)
                    scale = -scale;
                beat.a_num = scaled_operand(scale);
                beat.a_den = scaled_operand(scale);
            end
        end
        return beat;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 2);
        else if (r < 19)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue_beat(input rau_in_t beat, input rau_out_t want, input int gap);
        @(negedge clk);
        start <= 1'b1;
        item  <= beat;
        do
            @(posedge clk);
        while (busy);
        awaited_fractions.push_back(want);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_fractions.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch on %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     field, $signed(want), want, $signed(got), got);
    endtask

    always @(posedge clk)
    begin
        rau_out_t want;
        if (rst_n && done)
        begin
            if (awaited_fractions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result beat with nothing outstanding: %0d / %0d",
                             result.res_num, result.res_den);
            end
            else
            begin
                want = awaited_fractions.pop_front();
                if (result.res_num !== want.res_num)
                    report_mismatch("res_num", want.res_num, result.res_num);
                if (result.res_den !== want.res_den)
                    report_mismatch("res_den", want.res_den, result.res_den);
                if (result.zero_gcd !== want.zero_gcd)
                    report_mismatch("zero_gcd", 32'(want.zero_gcd), 32'(result.zero_gcd));
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rau_in_t beat;
        mismatches = 0;
        steady     = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_VECTORS; i++)
        begin
            beat = VECTORS[i].stim;
            issue_beat(beat,
                       VECTORS[i].has_want ? VECTORS[i].want : fraction_result(beat),
                       pick_gap());
        end
        drain_results();

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 40 == 0)
                steady = ($urandom_range(0, 2) == 0);
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_results();
            beat = random_beat();
            issue_beat(beat, fraction_result(beat), pick_gap());
        end

        drain_results();
        repeat (LINGER) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- rational_arithmetic_unit.f -----
+incdir+design
design/rau_pkg.sv
design/rau_div.sv
design/rational_arithmetic_unit.sv
verif/testbench.sv
